// ----- hw/rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find-and-replace core
// Beat payload structures, register indexes and size constants.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int MAX_NEEDLE      = 8;
   localparam int MAX_REPLACEMENT = 8;
   localparam int RESULT_LIMIT    = 8;

   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NEEDLE_BYTES       = 2'd0,
      CSR_NEEDLE_LENGTH      = 2'd1,
      CSR_REPLACEMENT_BYTES  = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       out_last;
   } rsp_type;

endpackage

// ----- hw/rtl/stream_find_replace_core.sv -----
// ----------------------------------------------------------------------------
// stream_find_replace_core: streaming byte find and replace
// Copies a byte stream through, replacing each leftmost non-overlapping
// occurrence of a programmable needle with a programmable replacement.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  req_     | in        | req_valid/req_stall | sfr_pkg::req_type (in_byte, in_last)
//  rsp_     | out       | rsp_valid/rsp_stall | sfr_pkg::rsp_type (byte, present, last)
//  csr_     | in        | csr_we              | csr_index, csr_wdata (64 bits)
//
// An input beat is processed in the cycle it is accepted and its results are
// held in an eight-entry result buffer that drains one beat per cycle while
// rsp_stall is low. A beat yielding zero or one result sustains one input beat
// per cycle while rsp_stall is low; a beat yielding more results occupies the
// buffer until they drain, stalling the input. Reset is synchronous and empties
// the window and the buffer and resets the registers. rsp_stall holds the current
// result; the input is taken again in the cycle the final buffered result leaves.
module stream_find_replace_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  sfr_pkg::req_type                          req_payload,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output sfr_pkg::rsp_type                          rsp_payload,
   input  logic                                      csr_we,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]            csr_wdata
);

   // configuration registers
   logic [8*sfr_pkg::MAX_NEEDLE-1:0]      needle_ff;
   logic [3:0]                            needle_len_ff;
   logic [8*sfr_pkg::MAX_REPLACEMENT-1:0] repl_ff;
   logic [3:0]                            repl_len_ff;

   // match window
   logic [7:0] win_ff [sfr_pkg::MAX_NEEDLE];
   logic [7:0] win_in [sfr_pkg::MAX_NEEDLE];
   logic [3:0] fill_ff;
   logic [3:0] fill_in;

   // result buffer
   logic [7:0] res_ff [sfr_pkg::RESULT_LIMIT];
   logic [7:0] res_in [sfr_pkg::RESULT_LIMIT];
   logic [3:0] rem_ff;
   logic [3:0] rem_in;
   logic [2:0] idx_ff;
   logic       last_ff;
   logic       empty_ff;

   // datapath
   logic [3:0] nlen;
   logic [3:0] rlen;
   logic [7:0] wbuf [sfr_pkg::MAX_NEEDLE];
   logic [3:0] fill_new;
   logic [3:0] excess;
   logic       full;
   logic [4:0] cmp_idx [sfr_pkg::MAX_NEEDLE];
   logic [7:0] cmp_byte [sfr_pkg::MAX_NEEDLE];
   logic [sfr_pkg::MAX_NEEDLE-1:0] lane_ok;
   logic       hit;
   logic [3:0] pop_cnt;
   logic [3:0] room;
   logic [3:0] rep_cnt;
   logic [3:0] total;
   logic [3:0] rep_idx [sfr_pkg::RESULT_LIMIT];
   logic [4:0] shift_idx [sfr_pkg::MAX_NEEDLE];

   logic req_fire;
   logic rsp_fire;

   assign rsp_valid = (rem_ff != 4'd0);
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign req_stall = (rem_ff > 4'd1) || ((rem_ff == 4'd1) && rsp_stall);
   assign req_fire  = req_valid && !req_stall;

   assign rsp_payload.out_byte     = empty_ff ? 8'd0 : res_ff[idx_ff];
   assign rsp_payload.byte_present = !empty_ff;
   assign rsp_payload.out_last     = last_ff && (rem_ff == 4'd1);

   always_comb begin
      // Out-of-range lengths saturate; a zero needle length counts as one.
      if (needle_len_ff == 4'd0) begin
         nlen = 4'd1;
      end else if (needle_len_ff > 4'(sfr_pkg::MAX_NEEDLE)) begin
         nlen = 4'(sfr_pkg::MAX_NEEDLE);
      end else begin
         nlen = needle_len_ff;
      end
      if (repl_len_ff > 4'(sfr_pkg::MAX_REPLACEMENT)) begin
         rlen = 4'(sfr_pkg::MAX_REPLACEMENT);
      end else begin
         rlen = repl_len_ff;
      end

      for (int j = 0; j < sfr_pkg::MAX_NEEDLE; j++) begin
         wbuf[j] = (4'(j) == fill_ff) ? req_payload.in_byte : win_ff[j];
      end
      fill_new = fill_ff + 4'd1;
      full     = (fill_new >= nlen);
      excess   = (fill_new > nlen) ? (fill_new - nlen) : 4'd0;

      // Bytes beyond a shortened needle are skipped; the compare starts there.
      for (int i = 0; i < sfr_pkg::MAX_NEEDLE; i++) begin
         cmp_idx[i]  = 5'(i) + {1'b0, excess};
         cmp_byte[i] = cmp_idx[i][4:3] == 2'd0 ? wbuf[cmp_idx[i][2:0]] : 8'd0;
         lane_ok[i]  = (4'(i) >= nlen) || (cmp_byte[i] == needle_ff[8*i +: 8]);
      end
      hit = full && (&lane_ok);

      if (!full) begin
         pop_cnt = 4'd0;
      end else if (hit) begin
         pop_cnt = excess;
      end else begin
         pop_cnt = excess + 4'd1;
      end
      if (req_payload.in_last && !hit) begin
         pop_cnt = fill_new;
      end

      room    = 4'(sfr_pkg::RESULT_LIMIT) - excess;
      rep_cnt = hit ? ((rlen < room) ? rlen : room) : 4'd0;
      total   = pop_cnt + rep_cnt;

      // Results are the popped window bytes followed by the replacement.
      for (int j = 0; j < sfr_pkg::RESULT_LIMIT; j++) begin
         rep_idx[j] = 4'(j) - pop_cnt;
         if (4'(j) < pop_cnt) begin
            res_in[j] = wbuf[j];
         end else begin
            res_in[j] = repl_ff[{rep_idx[j][2:0], 3'b000} +: 8];
         end
      end

      for (int i = 0; i < sfr_pkg::MAX_NEEDLE; i++) begin
         shift_idx[i] = 5'(i) + {1'b0, pop_cnt};
         win_in[i]    = shift_idx[i][4:3] == 2'd0 ? wbuf[shift_idx[i][2:0]] : 8'd0;
      end
      if (req_payload.in_last || hit) begin
         fill_in = 4'd0;
      end else begin
         fill_in = fill_new - pop_cnt;
      end

      // A final beat with nothing to emit still produces one empty result.
      if (req_payload.in_last && (total == 4'd0)) begin
         rem_in = 4'd1;
      end else begin
         rem_in = total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_ff     <= '0;
         needle_len_ff <= 4'd1;
         repl_ff       <= '0;
         repl_len_ff   <= 4'd0;
      end else if (csr_we) begin
         case (sfr_pkg::csr_index_type'(csr_index))
            sfr_pkg::CSR_NEEDLE_BYTES:       needle_ff     <= csr_wdata;
            sfr_pkg::CSR_NEEDLE_LENGTH:      needle_len_ff <= csr_wdata[3:0];
            sfr_pkg::CSR_REPLACEMENT_BYTES:  repl_ff       <= csr_wdata;
            sfr_pkg::CSR_REPLACEMENT_LENGTH: repl_len_ff   <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 4'd0;
         rem_ff  <= 4'd0;
         idx_ff  <= 3'd0;
      end else if (req_fire) begin
         fill_ff <= fill_in;
         rem_ff  <= rem_in;
         idx_ff  <= 3'd0;
      end else if (rsp_fire) begin
         rem_ff  <= rem_ff - 4'd1;
         idx_ff  <= idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         win_ff   <= win_in;
         res_ff   <= res_in;
         last_ff  <= req_payload.in_last;
         empty_ff <= (total == 4'd0);
      end
   end

   // The window never holds a full needle between beats.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff < 4'(sfr_pkg::MAX_NEEDLE))
      else $error("window fill out of range");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= 4'(sfr_pkg::RESULT_LIMIT))
      else $error("result count out of range");

   // A new beat is only taken once the buffer is empty or emptying.
   a_accept_drained: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (rem_ff == 4'd0) || ((rem_ff == 4'd1) && rsp_fire))
      else $error("input accepted over pending results");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.byte_present |-> rsp_payload.out_last)
      else $error("empty result without end mark");

   a_last_final: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_payload.out_last |=> (rem_ff == 4'd0) || $past(req_fire))
      else $error("results remain after end mark");

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stream_find_replace_core
// Sends byte strings shaped around the programmed needle, predicts the
// substituted output stream beat by beat and compares every result beat,
// with random idling on both channels and several register settings.
// ----------------------------------------------------------------------------
class replace_scoreboard;
   logic [63:0]      needle_bytes;
   logic [3:0]       needle_length;
   logic [63:0]      replacement_bytes;
   logic [3:0]       replacement_length;
   logic [7:0]       window [sfr_pkg::MAX_NEEDLE];
   int unsigned      window_fill;
   int unsigned      beat_results;
   sfr_pkg::rsp_type pending_output [$];
   int unsigned      errors;

   function new();
      needle_bytes       = '0;
      needle_length      = 4'd1;
      replacement_bytes  = '0;
      replacement_length = 4'd0;
      errors             = 0;
      clear_window();
   endfunction

   function void clear_window();
      foreach (window[i]) window[i] = 8'h00;
      window_fill = 0;
   endfunction

   function void write_register(sfr_pkg::csr_index_type idx, logic [63:0] value);
      case (idx)
         sfr_pkg::CSR_NEEDLE_BYTES:       needle_bytes = value;
         sfr_pkg::CSR_NEEDLE_LENGTH:      needle_length = value[3:0];
         sfr_pkg::CSR_REPLACEMENT_BYTES:  replacement_bytes = value;
         sfr_pkg::CSR_REPLACEMENT_LENGTH: replacement_length = value[3:0];
         default: ;
      endcase
   endfunction

   function int unsigned active_needle();
      if (needle_length == 0) return 1;
      if (needle_length > sfr_pkg::MAX_NEEDLE) return sfr_pkg::MAX_NEEDLE;
      return needle_length;
   endfunction

   function int unsigned active_replacement();
      if (replacement_length > sfr_pkg::MAX_REPLACEMENT) return sfr_pkg::MAX_REPLACEMENT;
      return replacement_length;
   endfunction

   function logic [7:0] pop_oldest();
      logic [7:0] oldest;
      oldest = window[0];
      for (int i = 1; i < sfr_pkg::MAX_NEEDLE; i++) window[i-1] = window[i];
      window[sfr_pkg::MAX_NEEDLE-1] = 8'h00;
      if (window_fill > 0) window_fill--;
      return oldest;
   endfunction

   // Anything beyond eight results from one input beat is silently dropped.
   function void emit(logic [7:0] value, logic present);
      sfr_pkg::rsp_type beat;
      if (beat_results >= sfr_pkg::RESULT_LIMIT) return;
      beat.out_byte     = value;
      beat.byte_present = present;
      beat.out_last     = 1'b0;
      pending_output.push_back(beat);
      beat_results++;
   endfunction

   function bit window_matches(int unsigned len);
      for (int i = 0; i < len; i++) begin
         if (window[i] != needle_bytes[8*i +: 8]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function void accept_byte(sfr_pkg::req_type beat);
      int unsigned      nlen;
      int unsigned      rlen;
      sfr_pkg::rsp_type tail;
      nlen = active_needle();
      rlen = active_replacement();
      beat_results = 0;
      window[window_fill] = beat.in_byte;
      window_fill++;
      // A needle shortened since the last beat leaves surplus bytes to pass through.
      while (window_fill > nlen) emit(pop_oldest(), 1'b1);
      if (window_fill == nlen) begin
         if (window_matches(nlen)) begin
            for (int i = 0; i < rlen; i++) emit(replacement_bytes[8*i +: 8], 1'b1);
            clear_window();
         end else begin
            emit(pop_oldest(), 1'b1);
         end
      end
      if (beat.in_last) begin
         while (window_fill > 0) emit(pop_oldest(), 1'b1);
         clear_window();
         if (beat_results == 0) emit(8'h00, 1'b0);
         tail = pending_output.pop_back();
         tail.out_last = 1'b1;
         pending_output.push_back(tail);
      end
   endfunction

   task report(string msg);
      if (errors < 200) $display("mismatch: %s", msg);
      errors++;
   endtask

   task check_output(sfr_pkg::rsp_type got);
      sfr_pkg::rsp_type want;
      if (pending_output.size() == 0) begin
         report($sformatf("unexpected beat byte %h present %b last %b",
                          got.out_byte, got.byte_present, got.out_last));
         return;
      end
      want = pending_output.pop_front();
      if (got.out_byte !== want.out_byte)
         report($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
      if (got.byte_present !== want.byte_present)
         report($sformatf("byte_present %b, expected %b",
                          got.byte_present, want.byte_present));
      if (got.out_last !== want.out_last)
         report($sformatf("out_last %b, expected %b", got.out_last, want.out_last));
   endtask
endclass

module testbench;

   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned BYTE_TARGET   = 370;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   sfr_pkg::req_type                req_payload;
   logic                            rsp_valid;
   logic                            rsp_stall;
   sfr_pkg::rsp_type                rsp_payload;
   logic                            csr_we;
   logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sfr_pkg::CSR_DATA_W-1:0]  csr_wdata;

   replace_scoreboard tracker;
   bit                calm = 1'b0;
   int unsigned       cycle_count = 0;
   int unsigned       bytes_sent = 0;

   stream_find_replace_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL stream_find_replace_core");
         $finish;
      end
   end

   function automatic int unsigned draw_wait();
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   // Result side: after each accepted beat, draw a fresh random wait and stall for it.
   always begin : result_sink
      int unsigned hold;
      @(posedge clock);
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_output(rsp_payload);
         hold = draw_wait();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(logic [7:0] value, logic last);
      int unsigned      gap;
      sfr_pkg::req_type beat;
      gap = draw_wait();
      beat.in_byte = value;
      beat.in_last = last;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.accept_byte(beat);
      bytes_sent++;
   endtask

   // Holds the input back until every predicted beat has come out; with settle set,
   // it then lets the block go quiet so the registers can be rewritten.
   task automatic drain_output(bit settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_output.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(sfr_pkg::csr_index_type idx, logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_register(idx, value);
   endtask

   task automatic end_writes();
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] with_length(int unsigned len);
      logic [63:0] value;
      value      = {$urandom, $urandom};
      value[3:0] = 4'(len);
      return value;
   endfunction

   function automatic logic [63:0] random_pattern();
      logic [63:0] value;
      case ($urandom_range(0, 4))
         0: value = {$urandom, $urandom};
         1: for (int i = 0; i < 8; i++) value[8*i +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
         2: value = $urandom_range(0, 1) ? '1 : '0;
         default:
            for (int i = 0; i < 8; i++) value[8*i +: 8] = 8'(8'h61 + $urandom_range(0, 3));
      endcase
      return value;
   endfunction

   function automatic int unsigned random_needle_length();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom_range(9, 15);
         2: return 8;
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   // With needle_only set, only the needle changes, which may shorten it mid-string.
   task automatic program_random(bit needle_only);
      if (needle_only) begin
         if ($urandom_range(0, 1)) write_reg(sfr_pkg::CSR_NEEDLE_BYTES, random_pattern());
         write_reg(sfr_pkg::CSR_NEEDLE_LENGTH, with_length(random_needle_length()));
      end else begin
         write_reg(sfr_pkg::CSR_NEEDLE_BYTES, random_pattern());
         write_reg(sfr_pkg::CSR_NEEDLE_LENGTH, with_length(random_needle_length()));
         write_reg(sfr_pkg::CSR_REPLACEMENT_BYTES, {$urandom, $urandom});
         write_reg(sfr_pkg::CSR_REPLACEMENT_LENGTH, with_length($urandom_range(0, 15)));
      end
      end_writes();
   endtask

   // Builds a string mostly from whole or partial needle copies, with some noise.
   task automatic send_string(bit with_last);
      logic [7:0]  text [$];
      logic [7:0]  value;
      int unsigned nlen;
      int unsigned cut;
      int unsigned bad;
      bit          noisy;
      nlen  = tracker.active_needle();
      noisy = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 4))
            0, 1: begin
               bad = $urandom_range(0, nlen - 1);
               for (int i = 0; i < nlen; i++) begin
                  value = tracker.needle_bytes[8*i +: 8];
                  if (noisy && i == bad) value[$urandom_range(0, 7)] ^= 1'b1;
                  text.push_back(value);
               end
            end
            2: begin
               cut = $urandom_range(1, nlen);
               for (int i = 0; i < cut; i++) text.push_back(tracker.needle_bytes[8*i +: 8]);
            end
            default: begin
               if ($urandom_range(0, 1))
                  text.push_back(tracker.needle_bytes[8*$urandom_range(0, nlen - 1) +: 8]);
               else
                  text.push_back(8'($urandom));
            end
         endcase
      end
      foreach (text[i]) send_byte(text[i], with_last && (i == text.size() - 1));
   endtask

   task automatic random_phase(int unsigned quota);
      int unsigned start;
      drain_output(1'b1);
      program_random($urandom_range(0, 3) == 0);
      calm  = ($urandom_range(0, 3) == 0);
      start = bytes_sent;
      while (bytes_sent - start < quota) begin
         send_string(1'b1);
         if ($urandom_range(0, 19) == 0) drain_output(1'b0);
      end
      // Leave a string open so the next setting applies to a half-filled window.
      if ($urandom_range(0, 1)) send_string(1'b0);
   endtask

   task automatic directed_cases();
      // Reset setting: a one-byte needle of zero, deleted on a match.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);
      drain_output(1'b1);
      // Zero needle length acts as one; an oversized replacement saturates at eight.
      write_reg(sfr_pkg::CSR_NEEDLE_BYTES, '1);
      write_reg(sfr_pkg::CSR_NEEDLE_LENGTH, 64'h0);
      write_reg(sfr_pkg::CSR_REPLACEMENT_BYTES, {$urandom, $urandom});
      write_reg(sfr_pkg::CSR_REPLACEMENT_LENGTH, 64'hF);
      end_writes();
      send_byte(8'hFF, 1'b0);
      send_byte(8'h12, 1'b1);
      drain_output(1'b1);
      // Oversized needle length saturates at eight.
      write_reg(sfr_pkg::CSR_NEEDLE_BYTES, 64'h4847_4645_4443_4241);
      write_reg(sfr_pkg::CSR_NEEDLE_LENGTH, 64'h9);
      write_reg(sfr_pkg::CSR_REPLACEMENT_LENGTH, 64'h3);
      end_writes();
      for (int i = 0; i < 8; i++) send_byte(8'(8'h41 + i), i == 7);
      for (int i = 0; i < 7; i++) send_byte(8'h41, 1'b0);
      drain_output(1'b1);
      // Shortening the needle to one byte flushes seven bytes, leaving room for a
      // single replacement byte in the eight results.
      write_reg(sfr_pkg::CSR_NEEDLE_BYTES, 64'hFFFF_FFFF_FFFF_FF41);
      write_reg(sfr_pkg::CSR_NEEDLE_LENGTH, 64'h1);
      write_reg(sfr_pkg::CSR_REPLACEMENT_LENGTH, 64'h8);
      end_writes();
      send_byte(8'h41, 1'b1);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      tracker     = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      directed_cases();
      while (bytes_sent < BYTE_TARGET) random_phase($urandom_range(15, 45));
      calm = 1'b0;
      drain_output(1'b1);
      if (tracker.errors == 0 && tracker.pending_output.size() == 0)
         $display("PASS stream_find_replace_core");
      else
         $display("FAIL stream_find_replace_core");
      $finish;
   end
endmodule
